FILE: design/mgq_pkg.sv
package mgq_pkg;

    localparam int DEF_COORD_BITS = 16;
    localparam int DEF_TEX_BITS   = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CODE_W     = 8;
    localparam int SIZE_W     = 9;
    localparam int WIDTH_W    = 13;
    localparam int HEIGHT_W   = 14;
    localparam int ORG_W      = 16;
    localparam int COLOR_W    = 32;

    // quotient bits retired per divider cycle
    localparam int DIV_RADIX  = 4;

    localparam logic signed [ORG_W-1:0]    ORIGIN_X_RST = -16'sd4096;
    localparam logic signed [ORG_W-1:0]    ORIGIN_Y_RST = 16'sd4096;
    localparam logic [WIDTH_W-1:0]         CHAR_W_RST   = 13'd64;
    localparam logic signed [HEIGHT_W-1:0] CHAR_H_RST   = -14'sd128;
    localparam logic [CODE_W-1:0]          FIRST_RST    = 8'd32;
    localparam logic [SIZE_W-1:0]          SIZE_RST     = 9'd96;
    localparam logic [COLOR_W-1:0]         COLOR_RST    = 32'hFFFF_FFFF;

    localparam logic [CODE_W-1:0] CODE_NUL     = 8'h00;
    localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'h0A;
    localparam logic [CODE_W-1:0] CODE_SPACE   = 8'h20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X    = 3'd0,
        CFG_ORIGIN_Y    = 3'd1,
        CFG_CHAR_WIDTH  = 3'd2,
        CFG_CHAR_HEIGHT = 3'd3,
        CFG_FIRST_CODE  = 3'd4,
        CFG_TABLE_SIZE  = 3'd5,
        CFG_DRAW_COLOR  = 3'd6
    } t_cfg_idx;

    typedef logic [2:0] t_step;

    localparam t_step STEP_WAIT = 3'd0;
    localparam t_step STEP_DIV  = 3'd1;
    localparam t_step STEP_V0   = 3'd2;
    localparam t_step STEP_V1   = 3'd3;
    localparam t_step STEP_V2   = 3'd4;
    localparam t_step STEP_V3   = 3'd5;
    localparam t_step STEP_V4   = 3'd6;
    localparam t_step STEP_V5   = 3'd7;

    // jump condition: taken goes to target, otherwise the step holds
    typedef enum logic [1:0] {
        C_GLYPH,
        C_DIV_DONE,
        C_OUT_FREE
    } t_cond;

    typedef struct packed {
        logic  ready;
        logic  div_run;
        logic  emit;
        logic  right;
        logic  bottom;
        logic  last;
        t_cond cond;
        t_step target;
    } t_uword;

    typedef struct packed {
        logic accept;
        logic glyph;
        logic div_last;
        logic out_free;
    } t_stat;

    function automatic t_uword ucode(input t_step s);
        t_uword w;
        unique case (s)
            STEP_WAIT: w = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, C_GLYPH,    STEP_DIV};
            STEP_DIV:  w = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, C_DIV_DONE, STEP_V0};
            STEP_V0:   w = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, C_OUT_FREE, STEP_V1};
            STEP_V1:   w = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, C_OUT_FREE, STEP_V2};
            STEP_V2:   w = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, C_OUT_FREE, STEP_V3};
            STEP_V3:   w = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, C_OUT_FREE, STEP_V4};
            STEP_V4:   w = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, C_OUT_FREE, STEP_V5};
            STEP_V5:   w = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, C_OUT_FREE, STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

FILE: design/mgq_useq.sv
module mgq_useq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mgq_pkg::t_stat i_stat,
    output mgq_pkg::t_uword o_uword
);
    import mgq_pkg::*;

    t_step r_step;
    t_step n_step;
    logic  take;

    assign o_uword = ucode(r_step);

    always_comb begin
        unique case (o_uword.cond)
            C_GLYPH:    take = i_stat.accept && i_stat.glyph;
            C_DIV_DONE: take = i_stat.div_last;
            C_OUT_FREE: take = i_stat.out_free;
            default:    take = 1'b0;
        endcase
        n_step = take ? o_uword.target : r_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

FILE: design/mgq_div.sv
module mgq_div #(
    parameter int TEX_BITS = mgq_pkg::DEF_TEX_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic                        i_run,
    input  logic [mgq_pkg::SIZE_W-1:0]  i_idx,
    input  logic [mgq_pkg::SIZE_W-1:0]  i_den,
    output logic [TEX_BITS-1:0]         o_quot_l,
    output logic [TEX_BITS-1:0]         o_quot_r,
    output logic                        o_last
);
    import mgq_pkg::*;

    localparam int DIV_CYC = (TEX_BITS + DIV_RADIX - 1) / DIV_RADIX;
    localparam int QW      = DIV_CYC * DIV_RADIX;
    localparam int NW      = QW + SIZE_W;
    localparam int PW      = TEX_BITS + SIZE_W;
    localparam int CW      = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

    logic [SIZE_W-1:0] r_rem [2];
    logic [SIZE_W-1:0] n_rem [2];
    logic [QW-1:0]     r_dvd [2];
    logic [QW-1:0]     n_dvd [2];
    logic [CW-1:0]     r_cnt;
    logic [SIZE_W-1:0] idx_p1;
    logic [PW-1:0]     prod [2];
    logic [NW-1:0]     num [2];

    // numerators (2^TEX_BITS - 1) * k without a multiplier
    always_comb begin
        idx_p1  = i_idx + SIZE_W'(1);
        prod[0] = {i_idx, {TEX_BITS{1'b0}}} - PW'(i_idx);
        prod[1] = {idx_p1, {TEX_BITS{1'b0}}} - PW'(idx_p1);
        num[0]  = NW'(prod[0]);
        num[1]  = NW'(prod[1]);
    end

    // restoring division, quotient bits shift in behind the dividend
    always_comb begin
        logic [SIZE_W:0]   t;
        logic [SIZE_W-1:0] r;
        logic [QW-1:0]     d;
        for (int l = 0; l < 2; l++) begin
            r = r_rem[l];
            d = r_dvd[l];
            for (int k = 0; k < DIV_RADIX; k++) begin
                t = {r, d[QW-1]};
                d = {d[QW-2:0], 1'b0};
                if (t >= {1'b0, i_den}) begin
                    t    = t - {1'b0, i_den};
                    d[0] = 1'b1;
                end
                r = t[SIZE_W-1:0];
            end
            n_rem[l] = r;
            n_dvd[l] = d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= '0;
        end else if (i_run) begin
            r_cnt <= r_cnt + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 2; l++) begin
            if (i_load) begin
                r_rem[l] <= num[l][NW-1:QW];
                r_dvd[l] <= num[l][QW-1:0];
            end else if (i_run) begin
                r_rem[l] <= n_rem[l];
                r_dvd[l] <= n_dvd[l];
            end
        end
    end

    assign o_last   = (r_cnt == CW'(DIV_CYC - 1));
    assign o_quot_l = r_dvd[0][TEX_BITS-1:0];
    assign o_quot_r = r_dvd[1][TEX_BITS-1:0];

endmodule

FILE: design/monospace_glyph_quad_generator_core.sv
// Monospaced glyph quad generator. Each accepted item is a character code (or a pen move
// request); the block keeps a saturating pen position and, for a code inside the glyph atlas,
// emits six vertices (left-top, right-top, left-bottom, right-top, right-bottom, left-bottom)
// with color and atlas coordinates. Pen moves, newline, NUL, space and unknown codes produce no
// vertices and leave the block ready for the next item. A visible glyph occupies the block until
// its sixth vertex is loaded, longer while the vertex output is stalled: the atlas coordinates
// come from a shared restoring divider that retires four quotient bits per cycle for both quad
// edges at once, then a microcoded sequencer sends one vertex per cycle, unless the output is
// stalled, through the output register. Input stall is high from the cycle after a glyph is
// taken until its sixth vertex has been loaded into the output register. The user must write
// configuration through the plain write port only while the block is idle; the block does not enforce it.
module monospace_glyph_quad_generator_core #(
    parameter int COORD_BITS = mgq_pkg::DEF_COORD_BITS,
    parameter int TEX_BITS   = mgq_pkg::DEF_TEX_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mgq_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mgq_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_req_type,
    input  logic [mgq_pkg::CODE_W-1:0]        i_char_code,
    input  logic                              i_first_of_string,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [COORD_BITS-1:0]      o_vertex_x,
    output logic signed [COORD_BITS-1:0]      o_vertex_y,
    output logic [mgq_pkg::COLOR_W-1:0]       o_vertex_color,
    output logic [TEX_BITS-1:0]               o_tex_u,
    output logic [TEX_BITS-1:0]               o_tex_v,
    output logic                              o_last_of_quad
);
    import mgq_pkg::*;

    localparam int SW = ((COORD_BITS > ORG_W) ? COORD_BITS : ORG_W) + 2;
    localparam logic signed [SW-1:0] C_HI = SW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] C_LO = -C_HI - SW'(1);
    localparam logic [TEX_BITS-1:0]  TMAX = {TEX_BITS{1'b1}};

    function automatic logic signed [COORD_BITS-1:0] sat_c(input logic signed [SW-1:0] v);
        logic signed [COORD_BITS-1:0] y;
        priority if (v > C_HI) begin
            y = COORD_BITS'(C_HI);
        end else if (v < C_LO) begin
            y = COORD_BITS'(C_LO);
        end else begin
            y = COORD_BITS'(v);
        end
        return y;
    endfunction

    logic signed [ORG_W-1:0]    r_org_x;
    logic signed [ORG_W-1:0]    r_org_y;
    logic [WIDTH_W-1:0]         r_char_w;
    logic signed [HEIGHT_W-1:0] r_char_h;
    logic [CODE_W-1:0]          r_first;
    logic [SIZE_W-1:0]          r_size;
    logic [COLOR_W-1:0]         r_color;

    logic signed [COORD_BITS-1:0] r_pen_x;
    logic signed [COORD_BITS-1:0] r_pen_y;
    logic                         r_stopped;
    logic signed [COORD_BITS-1:0] n_pen_x;
    logic signed [COORD_BITS-1:0] n_pen_y;
    logic                         n_stopped;

    logic signed [COORD_BITS-1:0] r_lx;
    logic signed [COORD_BITS-1:0] r_rx;
    logic signed [COORD_BITS-1:0] r_ty;
    logic signed [COORD_BITS-1:0] r_by;

    logic                         r_out_valid;
    logic signed [COORD_BITS-1:0] r_vx;
    logic signed [COORD_BITS-1:0] r_vy;
    logic [COLOR_W-1:0]           r_col;
    logic [TEX_BITS-1:0]          r_u;
    logic [TEX_BITS-1:0]          r_v;
    logic                         r_last;

    t_uword uw;
    t_stat  stat;

    logic signed [COORD_BITS-1:0] adv_x;
    logic signed [COORD_BITS-1:0] low_y;
    logic signed [COORD_BITS-1:0] home_x;
    logic signed [COORD_BITS-1:0] home_y;
    logic [CODE_W+1:0]            code_ext;
    logic [CODE_W+1:0]            range_lo;
    logic [CODE_W+1:0]            range_hi;
    logic                         in_range;
    logic                         stop_eff;
    logic                         is_glyph;
    logic                         accept;
    logic [CODE_W-1:0]            idx8;
    logic [TEX_BITS-1:0]          quot_l;
    logic [TEX_BITS-1:0]          quot_r;
    logic                         div_last;
    logic                         out_free;
    logic                         emit_fire;

    assign adv_x  = sat_c(SW'(r_pen_x) + SW'($signed({1'b0, r_char_w})));
    assign low_y  = sat_c(SW'(r_pen_y) + SW'(r_char_h));
    assign home_x = sat_c(SW'(r_org_x));
    assign home_y = sat_c(SW'(r_org_y));

    assign code_ext = (CODE_W + 2)'(i_char_code);
    assign range_lo = (CODE_W + 2)'(r_first);
    assign range_hi = range_lo + (CODE_W + 2)'(r_size);
    assign in_range = (code_ext >= range_lo) && (code_ext < range_hi);
    assign stop_eff = r_stopped && !i_first_of_string;
    assign is_glyph = !i_req_type && !stop_eff && in_range &&
                      (i_char_code != CODE_NUL) && (i_char_code != CODE_NEWLINE) &&
                      (i_char_code != CODE_SPACE);
    assign idx8     = i_char_code - r_first;

    assign accept    = i_in_valid && uw.ready;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign emit_fire = uw.emit && out_free;

    always_comb begin
        stat.accept   = accept;
        stat.glyph    = is_glyph;
        stat.div_last = div_last;
        stat.out_free = out_free;
    end

    mgq_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_uword (uw)
    );

    mgq_div #(
        .TEX_BITS (TEX_BITS)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept && is_glyph),
        .i_run    (uw.div_run),
        .i_idx    (SIZE_W'(idx8)),
        .i_den    (r_size),
        .o_quot_l (quot_l),
        .o_quot_r (quot_r),
        .o_last   (div_last)
    );

    always_comb begin
        n_pen_x   = r_pen_x;
        n_pen_y   = r_pen_y;
        n_stopped = r_stopped;
        if (accept) begin
            if (i_req_type) begin
                n_pen_x = home_x;
                n_pen_y = home_y;
            end else begin
                n_stopped = stop_eff;
                if (!stop_eff) begin
                    priority if (i_char_code == CODE_NUL) begin
                        n_stopped = 1'b1;
                    end else if (i_char_code == CODE_NEWLINE) begin
                        n_pen_x = home_x;
                        n_pen_y = low_y;
                    end else begin
                        // glyph, space and unknown codes all advance
                        n_pen_x = adv_x;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x     <= ORIGIN_X_RST;
            r_org_y     <= ORIGIN_Y_RST;
            r_char_w    <= CHAR_W_RST;
            r_char_h    <= CHAR_H_RST;
            r_first     <= FIRST_RST;
            r_size      <= SIZE_RST;
            r_color     <= COLOR_RST;
            r_pen_x     <= sat_c(SW'(ORIGIN_X_RST));
            r_pen_y     <= sat_c(SW'(ORIGIN_Y_RST));
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_ORIGIN_X:    r_org_x  <= $signed(i_cfg_data[ORG_W-1:0]);
                    CFG_ORIGIN_Y:    r_org_y  <= $signed(i_cfg_data[ORG_W-1:0]);
                    CFG_CHAR_WIDTH:  r_char_w <= i_cfg_data[WIDTH_W-1:0];
                    CFG_CHAR_HEIGHT: r_char_h <= $signed(i_cfg_data[HEIGHT_W-1:0]);
                    CFG_FIRST_CODE:  r_first  <= i_cfg_data[CODE_W-1:0];
                    CFG_TABLE_SIZE:  r_size   <= i_cfg_data[SIZE_W-1:0];
                    CFG_DRAW_COLOR:  r_color  <= i_cfg_data[COLOR_W-1:0];
                    default: ;
                endcase
            end
            r_pen_x   <= n_pen_x;
            r_pen_y   <= n_pen_y;
            r_stopped <= n_stopped;
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_glyph) begin
            r_lx <= r_pen_x;
            r_rx <= adv_x;
            r_ty <= r_pen_y;
            r_by <= low_y;
        end
        if (emit_fire) begin
            r_vx   <= uw.right  ? r_rx : r_lx;
            r_vy   <= uw.bottom ? r_by : r_ty;
            r_u    <= uw.right  ? quot_r : quot_l;
            r_v    <= uw.bottom ? TMAX : '0;
            r_col  <= r_color;
            r_last <= uw.last;
        end
    end

    assign o_in_stall     = !uw.ready;
    assign o_out_valid    = r_out_valid;
    assign o_vertex_x     = r_vx;
    assign o_vertex_y     = r_vy;
    assign o_vertex_color = r_col;
    assign o_tex_u        = r_u;
    assign o_tex_v        = r_v;
    assign o_last_of_quad = r_last;

endmodule

FILE: design/mgq_checker.sv
module mgq_checker #(
    parameter int COORD_BITS = mgq_pkg::DEF_COORD_BITS,
    parameter int TEX_BITS   = mgq_pkg::DEF_TEX_BITS
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              i_req_type,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic signed [COORD_BITS-1:0]      o_vertex_x,
    input logic signed [COORD_BITS-1:0]      o_vertex_y,
    input logic [mgq_pkg::COLOR_W-1:0]       o_vertex_color,
    input logic [TEX_BITS-1:0]               o_tex_u,
    input logic [TEX_BITS-1:0]               o_tex_v,
    input logic                              o_last_of_quad
);

    localparam logic [TEX_BITS-1:0] TMAX = {TEX_BITS{1'b1}};

    // a held vertex does not move
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_vertex_x) &&
        $stable(o_vertex_y) && $stable(o_vertex_color) && $stable(o_tex_u) &&
        $stable(o_tex_v) && $stable(o_last_of_quad))
        else $error("vertex changed while stalled");

    // the closing vertex of a quad is a bottom one
    a_last_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_of_quad |-> o_tex_v == TMAX)
        else $error("last vertex not on the bottom edge");

    // only the sixth vertex may still wait while new items are taken
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_in_stall |-> o_last_of_quad)
        else $error("quad unfinished while taking items");

    // vertices of one quad follow back to back once taken
    a_quad_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_of_quad && !i_out_stall |=> o_out_valid)
        else $error("gap inside a quad");

    // a pen move never occupies the block
    a_move_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_req_type |=> !o_in_stall)
        else $error("pen move stalled the input");

endmodule

bind monospace_glyph_quad_generator_core mgq_checker #(
    .COORD_BITS (COORD_BITS),
    .TEX_BITS   (TEX_BITS)
) u_mgq_checker (.*);
